// ===== hw/rtl/cprf_pkg.sv =====
// Package: transfer types, action and select codes for the CPU register file.
`timescale 1ns / 1ps
package cprf_pkg;

  typedef enum logic [2:0] {
    ACT_READ16      = 3'd0,
    ACT_WRITE16     = 3'd1,
    ACT_READ8       = 3'd2,
    ACT_WRITE8      = 3'd3,
    ACT_READ8_CODE  = 3'd4,
    ACT_WRITE8_CODE = 3'd5,
    ACT_SET_FLAGS   = 3'd6,
    ACT_NOP         = 3'd7
  } action_t;

  localparam logic [3:0] SEL_HL   = 4'd11;
  localparam logic [3:0] SEL_PC   = 4'd12;
  localparam logic [3:0] SEL_SP   = 4'd13;
  localparam logic [3:0] SEL_NONE = 4'd14;

  localparam logic [2:0] IDX_A = 3'd0;
  localparam logic [2:0] IDX_F = 3'd1;
  localparam logic [2:0] IDX_H = 3'd6;
  localparam logic [2:0] IDX_L = 3'd7;

  localparam logic [2:0] CODE_INDIRECT = 3'd6;

  localparam logic [1:0] FLAG_CLEAR = 2'd0;
  localparam logic [1:0] FLAG_SET   = 2'd1;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam int FLAG_Z_BIT = 7;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  reg_select;
    logic [2:0]  operand_code;
    logic [15:0] write_value;
    logic [1:0]  zero_flag;
    logic [1:0]  subtract_flag;
    logic [1:0]  half_carry_flag;
    logic [1:0]  carry_flag;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [1:0]  mem_request;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic        select_error;
  } out_item_t;

  // Operand code to byte register index: B C D E H L (HL) A.
  function automatic logic [2:0] code_to_index(input logic [2:0] code);
    logic [2:0] idx;
    idx = IDX_A;
    case (code)
      3'd0:    idx = 3'd2;
      3'd1:    idx = 3'd3;
      3'd2:    idx = 3'd4;
      3'd3:    idx = 3'd5;
      3'd4:    idx = IDX_H;
      3'd5:    idx = IDX_L;
      default: idx = IDX_A;
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/cpu_register_file_pairs_flags_unit.sv =====
// Top level: CPU register file with byte registers, pairs, PC, SP and flag update.
// Each accepted start passes through an input register and then a result register before out_valid.
// Throughput: one transfer per cycle; busy is always low, state updates in the
// result stage so back-to-back transfers see each other's writes in order.
// Receiver cannot stall: each result is shown for exactly one cycle.
// Reset: synchronous active-low rst_n clears all byte registers, PC, SP and valids.
`timescale 1ns / 1ps
module cpu_register_file_pairs_flags_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cprf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output cprf_pkg::out_item_t  out_data
);

  logic                valid_r;
  cprf_pkg::in_item_t  item_r;
  logic                out_valid_r;
  cprf_pkg::out_item_t out_data_r;

  logic [7:0]  regs_r [8];
  logic [7:0]  regs_nxt [8];
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] sp_r, sp_nxt;
  cprf_pkg::out_item_t res_nxt;

  logic [3:0]  sel;
  logic [2:0]  pair_hi;
  logic [2:0]  pair_lo;
  logic [15:0] pair_val;
  logic [15:0] hl_val;
  logic [2:0]  byte_idx;
  logic        byte_ok;
  logic        indirect;
  logic        is_write;
  logic [7:0]  f_val;
  logic [1:0]  flag_codes [4];

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sel      = item_r.reg_select;
  assign pair_hi  = {sel[1:0], 1'b0};
  assign pair_lo  = {sel[1:0], 1'b1};
  assign pair_val = {regs_r[pair_hi], regs_r[pair_lo]};
  assign hl_val   = {regs_r[cprf_pkg::IDX_H], regs_r[cprf_pkg::IDX_L]};

  assign flag_codes[0] = item_r.zero_flag;
  assign flag_codes[1] = item_r.subtract_flag;
  assign flag_codes[2] = item_r.half_carry_flag;
  assign flag_codes[3] = item_r.carry_flag;

  always_comb begin
    byte_idx = cprf_pkg::IDX_A;
    byte_ok  = 1'b0;
    indirect = 1'b0;
    is_write = (item_r.action == cprf_pkg::ACT_WRITE8) ||
               (item_r.action == cprf_pkg::ACT_WRITE8_CODE);
    if ((item_r.action == cprf_pkg::ACT_READ8) || (item_r.action == cprf_pkg::ACT_WRITE8)) begin
      if (!sel[3]) begin
        byte_idx = sel[2:0];
        byte_ok  = 1'b1;
      end else if (sel == cprf_pkg::SEL_HL) begin
        indirect = 1'b1;
        byte_ok  = 1'b1;
      end
    end else begin
      byte_ok  = 1'b1;
      indirect = (item_r.operand_code == cprf_pkg::CODE_INDIRECT);
      byte_idx = cprf_pkg::code_to_index(item_r.operand_code);
    end
  end

  always_comb begin
    f_val = regs_r[cprf_pkg::IDX_F];
    for (int i = 0; i < 4; i++) begin
      if (flag_codes[i] == cprf_pkg::FLAG_CLEAR) begin
        f_val[cprf_pkg::FLAG_Z_BIT - i] = 1'b0;
      end else if (flag_codes[i] == cprf_pkg::FLAG_SET) begin
        f_val[cprf_pkg::FLAG_Z_BIT - i] = 1'b1;
      end
    end
  end

  always_comb begin
    regs_nxt = regs_r;
    pc_nxt   = pc_r;
    sp_nxt   = sp_r;
    res_nxt  = '0;
    case (cprf_pkg::action_t'(item_r.action))
      cprf_pkg::ACT_READ16: begin
        if (!sel[3]) begin
          res_nxt.read_value = {8'h00, regs_r[sel[2:0]]};
        end else if (sel[3:2] == 2'b10) begin
          res_nxt.read_value = pair_val;
        end else if (sel == cprf_pkg::SEL_PC) begin
          res_nxt.read_value = pc_r;
        end else if (sel == cprf_pkg::SEL_SP) begin
          res_nxt.read_value = sp_r;
        end else if (sel != cprf_pkg::SEL_NONE) begin
          res_nxt.select_error = 1'b1;
        end
      end
      cprf_pkg::ACT_WRITE16: begin
        if (!sel[3]) begin
          regs_nxt[sel[2:0]] = item_r.write_value[7:0];
        end else if (sel[3:2] == 2'b10) begin
          regs_nxt[pair_hi] = item_r.write_value[15:8];
          regs_nxt[pair_lo] = item_r.write_value[7:0];
        end else if (sel == cprf_pkg::SEL_PC) begin
          pc_nxt = item_r.write_value;
        end else if (sel == cprf_pkg::SEL_SP) begin
          sp_nxt = item_r.write_value;
        end else if (sel != cprf_pkg::SEL_NONE) begin
          res_nxt.select_error = 1'b1;
        end
      end
      cprf_pkg::ACT_READ8, cprf_pkg::ACT_WRITE8,
      cprf_pkg::ACT_READ8_CODE, cprf_pkg::ACT_WRITE8_CODE: begin
        if (!byte_ok) begin
          res_nxt.select_error = 1'b1;
        end else if (indirect) begin
          res_nxt.mem_address = hl_val;
          if (is_write) begin
            res_nxt.mem_request    = cprf_pkg::MEM_WRITE;
            res_nxt.mem_write_data = item_r.write_value[7:0];
          end else begin
            res_nxt.mem_request = cprf_pkg::MEM_READ;
          end
        end else if (is_write) begin
          regs_nxt[byte_idx] = item_r.write_value[7:0];
        end else begin
          res_nxt.read_value = {8'h00, regs_r[byte_idx]};
        end
      end
      cprf_pkg::ACT_SET_FLAGS: begin
        regs_nxt[cprf_pkg::IDX_F] = f_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      sp_r        <= '0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      valid_r     <= start;
      out_valid_r <= valid_r;
      if (valid_r) begin
        regs_r <= regs_nxt;
        pc_r   <= pc_nxt;
        sp_r   <= sp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_data;
    end
    if (valid_r) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
